FILE: sv/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue core: operation
// and status codes, controller states and fixed port widths.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int unsigned DEPTH_DEF      = 1024;
   localparam int unsigned DATA_WIDTH_DEF = 32;

   localparam int unsigned KIND_W   = 3;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned INDEX_W  = 10;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OCC_W    = 11;

   typedef enum logic [KIND_W-1:0] {
      K_PUSH_BACK  = 3'd0,
      K_PUSH_FRONT = 3'd1,
      K_POP_BACK   = 3'd2,
      K_POP_FRONT  = 3'd3,
      K_READ       = 3'd4,
      K_WRITE      = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

endpackage

FILE: sv/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Fixed-capacity deque over a circular store: push/pop at both ends and
// indexed read/write counted from the front, one result word per command.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   req_kind, req_value, req_index          start && !busy
//  result    rsp_read_data, rsp_status, rsp_occupancy rsp_valid, one cycle
//
//  A command passes through an execute cycle that checks limits, updates
//  pointer and count and accesses the store, then the result cycle, in which
//  the registered store output is shown. busy is high in the execute cycle
//  only, so a new command may start during the result cycle.
//  Reset is synchronous; it clears front pointer and count. Store contents
//  are undefined until written; there is no clearing pass.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
   parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
   parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dq_pkg::KIND_W-1:0]     req_kind,
   input  logic [dq_pkg::VALUE_W-1:0]    req_value,
   input  logic [dq_pkg::INDEX_W-1:0]    req_index,
   output logic                          rsp_valid,
   output logic [dq_pkg::VALUE_W-1:0]    rsp_read_data,
   output logic [dq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [dq_pkg::OCC_W-1:0]      rsp_occupancy
);

   localparam int unsigned AW   = $clog2(DEPTH);
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned IW   = (CW > dq_pkg::INDEX_W) ? CW : dq_pkg::INDEX_W;
   localparam int unsigned WIDE = (DATA_WIDTH > dq_pkg::VALUE_W) ? DATA_WIDTH
                                                                 : dq_pkg::VALUE_W;

   dq_pkg::state_type  state_ff, state_in;
   dq_pkg::kind_type   kind_ff;
   logic [dq_pkg::VALUE_W-1:0] value_ff;
   logic [dq_pkg::INDEX_W-1:0] index_ff;
   logic [AW-1:0]      front_ff, front_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff;
   dq_pkg::status_type rsp_status_ff, status_in;
   logic [dq_pkg::OCC_W-1:0] rsp_occ_ff;
   logic               rd_ok_ff, rd_ok_in;

   logic               accept, exec;
   logic               full, empty, idx_ok;
   logic [AW-1:0]      pos, slot, front_dec, front_inc;
   logic [AW:0]        slot_sum;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_addr;
   logic [WIDE-1:0]    value_ext, rdata_ext;
   logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

   // control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dq_pkg::S_IDLE: begin
            if (start) begin
               state_in = dq_pkg::S_EXEC;
            end
         end
         dq_pkg::S_EXEC: begin
            state_in = dq_pkg::S_IDLE;
         end
         default: begin
            state_in = dq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy   = (state_ff == dq_pkg::S_EXEC);
      exec   = (state_ff == dq_pkg::S_EXEC);
      accept = start && (state_ff == dq_pkg::S_IDLE);
   end

   // ring addressing
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign idx_ok    = (IW'(index_ff) < IW'(count_ff));
   assign pos       = (kind_ff == dq_pkg::K_PUSH_BACK) ? AW'(count_ff) : AW'(index_ff);
   assign slot_sum  = {1'b0, front_ff} + {1'b0, pos};
   assign slot      = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                   : AW'(slot_sum);
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);

   assign value_ext = WIDE'(value_ff);
   assign mem_wdata = value_ext[DATA_WIDTH-1:0];

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = dq_pkg::ST_OK;
      rd_ok_in  = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = slot;
      case (kind_ff)
         dq_pkg::K_PUSH_BACK: begin
            if (full) begin
               status_in = dq_pkg::ST_OVER;
            end else begin
               mem_we   = exec;
               count_in = count_ff + CW'(1);
            end
         end
         dq_pkg::K_PUSH_FRONT: begin
            mem_addr = front_dec;
            if (full) begin
               status_in = dq_pkg::ST_OVER;
            end else begin
               mem_we   = exec;
               front_in = front_dec;
               count_in = count_ff + CW'(1);
            end
         end
         dq_pkg::K_POP_BACK: begin
            if (empty) begin
               status_in = dq_pkg::ST_UNDER;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         dq_pkg::K_POP_FRONT: begin
            if (empty) begin
               status_in = dq_pkg::ST_UNDER;
            end else begin
               front_in = front_inc;
               count_in = count_ff - CW'(1);
            end
         end
         dq_pkg::K_READ: begin
            if (!idx_ok) begin
               status_in = dq_pkg::ST_RANGE;
            end else begin
               mem_re   = exec;
               rd_ok_in = 1'b1;
            end
         end
         dq_pkg::K_WRITE: begin
            if (!idx_ok) begin
               status_in = dq_pkg::ST_RANGE;
            end else begin
               mem_we = exec;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= exec;
         if (exec) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= dq_pkg::kind_type'(req_kind);
         value_ff <= req_value;
         index_ff <= req_index;
      end
      if (exec) begin
         rsp_status_ff <= status_in;
         rsp_occ_ff    <= dq_pkg::OCC_W'(count_in);
         rd_ok_ff      <= rd_ok_in;
      end
   end

   dq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dq_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rdata_ext     = WIDE'(mem_rdata);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rd_ok_ff ? rdata_ext[dq_pkg::VALUE_W-1:0] : '0;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

FILE: sv/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Single-port element store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
   parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_WIDTH-1:0]    wdata,
   output logic [DATA_WIDTH-1:0]    rdata
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on command/result timing and result consistency.
// ----------------------------------------------------------------------------
module dq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [dq_pkg::VALUE_W-1:0]  rsp_read_data,
   input logic [dq_pkg::STATUS_W-1:0] rsp_status,
   input logic [dq_pkg::OCC_W-1:0]    rsp_occupancy
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("command accepted without going busy");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("result missing two cycles after command");

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_under_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dq_pkg::ST_UNDER) |-> (rsp_occupancy == '0))
      else $error("underflow reported with non-zero occupancy");

   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_data != '0) |-> (rsp_status == dq_pkg::ST_OK))
      else $error("read data returned on a failed command");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);
